// ----- rtl/skl_pkg.sv -----
// Package for the sequential keyed list: capacity, derived widths, mode and
// status codes, item, result, entry and cell control types. No dependencies.
`timescale 1ns / 1ps

package skl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_SEARCH = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_CMP,
    ACT_INSERT,
    ACT_DELETE
  } act_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] key;
    logic [63:0]        entry_payload;
    logic [POS_W-1:0]   position;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] found_index;
    logic [4:0] entry_count;
  } result_t;

  typedef struct packed {
    logic [31:0] key;
    logic [63:0] payload;
  } entry_t;

  typedef struct packed {
    act_e             action;
    logic [IDX_W-1:0] at;
    logic [CNT_W-1:0] count;
    entry_t           entry;
  } cell_ctrl_t;

endpackage

// ----- rtl/skl_cell.sv -----
// One list cell: holds a single entry, shifts it to or from its neighbours
// and registers a key match. Depends on skl_pkg.
`timescale 1ns / 1ps

module skl_cell (
  input  logic                      clk_i,
  input  logic [skl_pkg::IDX_W-1:0] cell_idx_i,
  input  skl_pkg::cell_ctrl_t       ctrl_i,
  input  skl_pkg::entry_t           left_i,
  input  skl_pkg::entry_t           right_i,
  output skl_pkg::entry_t           entry_o,
  output logic                      match_o
);
  import skl_pkg::*;

  entry_t entry_q, entry_d;
  logic   match_q, match_d;

  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    unique case (ctrl_i.action)
      ACT_HOLD: begin
      end
      ACT_CMP: begin
        match_d = (entry_q.key == ctrl_i.entry.key) &&
                  (CNT_W'(cell_idx_i) < ctrl_i.count);
      end
      ACT_INSERT: begin
        if (cell_idx_i > ctrl_i.at) begin
          entry_d = left_i;
        end else if (cell_idx_i == ctrl_i.at) begin
          entry_d = ctrl_i.entry;
        end
      end
      ACT_DELETE: begin
        if (cell_idx_i >= ctrl_i.at) begin
          entry_d = right_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ----- rtl/sequential_keyed_list.sv -----
// Top level of the sequential keyed list: command sequencer over a row of
// skl_cell instances. Depends on skl_pkg and skl_cell.
`timescale 1ns / 1ps

// An item is taken when start_i is high and busy_o is low. It is latched while
// idle; every cell then compares its key in the S_CMP state, and in S_EXEC the
// first matching cell is picked and the row shifts. The result
// then sits on result_o for exactly one cycle with done_o high, and must be
// captured there; in that same cycle busy_o is already low, so the next item
// may be started. Stored entries need no clearing after reset.
module sequential_keyed_list (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  skl_pkg::item_t   item_i,
  output logic             busy_o,
  output logic             done_o,
  output skl_pkg::result_t result_o
);
  import skl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q, done_d;
  item_t            item_q;
  result_t          result_q, result_d;

  cell_ctrl_t          ctrl;
  entry_t              cell_entry [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [IDX_W-1:0]    first_idx;
  logic                found;
  logic                full;
  logic                accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign full   = (count_q >= CNT_W'(CAPACITY));
  assign found  = |match;

  always_comb begin
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left, right;
    if (g == 0) begin : g_first
      assign left = ctrl.entry;
    end else begin : g_mid_l
      assign left = cell_entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_entry[g+1];
    end
    skl_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .ctrl_i     (ctrl),
      .left_i     (left),
      .right_i    (right),
      .entry_o    (cell_entry[g]),
      .match_o    (match[g])
    );
  end

  always_comb begin
    state_d                = state_q;
    count_d                = count_q;
    done_d                 = 1'b0;
    result_d               = result_q;
    ctrl.action            = ACT_HOLD;
    ctrl.at                = '0;
    ctrl.count             = count_q;
    ctrl.entry.key         = item_q.key;
    ctrl.entry.payload     = item_q.entry_payload;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.action = ACT_CMP;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        result_d.status      = ST_OK;
        result_d.found_index = '0;
        unique case (item_q.mode)
          MODE_INSERT: begin
            if (full) begin
              result_d.status = ST_FULL;
            end else if (CMP_W'(item_q.position) > CMP_W'(count_q)) begin
              result_d.status = ST_BADPOS;
            end else begin
              ctrl.action = ACT_INSERT;
              ctrl.at     = IDX_W'(item_q.position);
              count_d     = count_q + CNT_W'(1);
            end
          end
          MODE_APPEND: begin
            if (full) begin
              result_d.status = ST_FULL;
            end else begin
              ctrl.action = ACT_INSERT;
              ctrl.at     = IDX_W'(count_q);
              count_d     = count_q + CNT_W'(1);
            end
          end
          MODE_DELETE: begin
            if (!found) begin
              result_d.status = ST_NOTFOUND;
            end else begin
              ctrl.action = ACT_DELETE;
              ctrl.at     = first_idx;
              count_d     = count_q - CNT_W'(1);
            end
          end
          MODE_SEARCH: begin
            if (found) begin
              result_d.found_index = 4'(first_idx);
            end else begin
              result_d.status = ST_NOTFOUND;
            end
          end
          MODE_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
        result_d.entry_count = 5'(count_d);
        done_d               = 1'b1;
        state_d              = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      done_q   <= done_d;
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("item accepted without going busy");

  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("item finished without result");
`endif

endmodule

// ----- tb/skl_checker.sv -----
// Checker for the sequential keyed list: watches the item and result channels,
// keeps its own copy of the list and compares every result. Depends on skl_pkg.
`timescale 1ns / 1ps

module skl_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  skl_pkg::item_t   item_i,
  input  logic             done_i,
  input  skl_pkg::result_t result_i,
  output int               fail_count_o,
  output int               pending_count_o,
  output int               checked_count_o
);
  import skl_pkg::*;

  logic [31:0] held_keys     [CAPACITY];
  logic [63:0] held_payloads [CAPACITY];
  int          held_count;
  result_t     awaited_results[$];

  function automatic result_t apply_list_op(item_t op);
    result_t res;
    int      first_hit;
    res       = '0;
    first_hit = -1;
    for (int i = held_count - 1; i >= 0; i--) begin
      if (held_keys[i] == op.key) first_hit = i;
    end
    case (op.mode)
      MODE_INSERT: begin
        if (held_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (int'(op.position) > held_count) begin
          res.status = ST_BADPOS;
        end else begin
          for (int i = held_count; i > int'(op.position); i--) begin
            held_keys[i]     = held_keys[i - 1];
            held_payloads[i] = held_payloads[i - 1];
          end
          held_keys[op.position]     = op.key;
          held_payloads[op.position] = op.entry_payload;
          held_count++;
        end
      end
      MODE_APPEND: begin
        if (held_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          held_keys[held_count]     = op.key;
          held_payloads[held_count] = op.entry_payload;
          held_count++;
        end
      end
      MODE_DELETE: begin
        if (first_hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          for (int i = first_hit; i + 1 < held_count; i++) begin
            held_keys[i]     = held_keys[i + 1];
            held_payloads[i] = held_payloads[i + 1];
          end
          held_count--;
        end
      end
      MODE_SEARCH: begin
        if (first_hit < 0) res.status = ST_NOTFOUND;
        else res.found_index = 4'(first_hit);
      end
      MODE_CLEAR: begin
        held_count = 0;
      end
      default: ;
    endcase
    res.entry_count = 5'(held_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t due;
    if (!rst_ni) begin
      held_count      = 0;
      fail_count_o    = 0;
      checked_count_o = 0;
      awaited_results.delete();
      pending_count_o = 0;
    end else begin
      if (done_i) begin
        if (awaited_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with none awaited: expected nothing, got %p", $time,
                   result_i);
        end else begin
          due = awaited_results.pop_front();
          checked_count_o++;
          if (result_i.status !== due.status) begin
            fail_count_o++;
            $display("%0t: status expected %0d, got %0d", $time, due.status,
                     result_i.status);
          end
          if (result_i.found_index !== due.found_index) begin
            fail_count_o++;
            $display("%0t: found_index expected %0d, got %0d", $time, due.found_index,
                     result_i.found_index);
          end
          if (result_i.entry_count !== due.entry_count) begin
            fail_count_o++;
            $display("%0t: entry_count expected %0d, got %0d", $time, due.entry_count,
                     result_i.entry_count);
          end
        end
      end
      if (start_i && !busy_i) awaited_results.push_back(apply_list_op(item_i));
      pending_count_o = awaited_results.size();
    end
  end

endmodule

// ----- tb/sequential_keyed_list_tb.sv -----
// Testbench top for the sequential keyed list: clock, reset, directed and random
// items with random gaps, and the verdict. Depends on skl_pkg, skl_checker and sequential_keyed_list.
`timescale 1ns / 1ps

module sequential_keyed_list_tb;
  import skl_pkg::*;

  localparam int          RANDOM_ITEMS      = 1810;
  localparam int          WATCHDOG_LIMIT    = 2000;
  localparam logic [2:0]  FIRST_UNUSED_MODE = 3'(MODE_CLEAR) + 3'd1;
  localparam logic [2:0]  LAST_UNUSED_MODE  = '1;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start_i;
  item_t   item_i;
  logic    busy_o;
  logic    done_o;
  result_t result_o;

  int          fail_count;
  int          pending_count;
  int          checked_count;
  int          idle_cycles = 0;
  int          mode_sent [8];
  logic [31:0] key_pool [8];

  sequential_keyed_list dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  skl_checker list_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .item_i          (item_i),
    .done_i          (done_o),
    .result_i        (result_o),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count),
    .checked_count_o (checked_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic item_t make_item(input logic [2:0] mode, input logic [31:0] key,
                                      input int pos);
    item_t it;
    it.mode          = mode;
    it.key           = key;
    it.entry_payload = {$urandom, $urandom};
    it.position      = 5'(pos);
    return it;
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 4) != 0) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // hold start high across back-to-back items, drop it only for a gap
  task automatic send_item(input item_t it, input int gap);
    repeat (gap) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    mode_sent[it.mode]++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  initial begin
    item_t       it;
    int          random_sent;
    int          phase_kind;
    int          phase_len;
    int          roll;
    int          pos;
    bit          no_gaps;
    int          ins_cut, app_cut, del_cut, srch_cut, clr_cut;
    logic [2:0]  mode;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    item_i      = '0;
    random_sent = 0;
    foreach (mode_sent[m]) mode_sent[m] = 0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int k = 4; k < 8; k++) key_pool[k] = $urandom;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty list, both key extremes, positions at and past the end,
    // duplicates, head and tail deletes, unused modes, clear
    send_item(make_item(MODE_SEARCH, 32'h0, 0), 0);
    send_item(make_item(MODE_DELETE, 32'h0, 0), 0);
    send_item(make_item(MODE_INSERT, 32'h1, 1), 0);
    it = make_item(MODE_INSERT, 32'h8000_0000, 0);
    it.entry_payload = '1;
    send_item(it, 0);
    it = make_item(MODE_APPEND, 32'h7FFF_FFFF, 0);
    it.entry_payload = '0;
    send_item(it, 1);
    send_item(make_item(MODE_INSERT, 32'hFFFF_FFFF, 1), 0);
    send_item(make_item(MODE_INSERT, 32'h0, 3), 2);
    send_item(make_item(MODE_INSERT, 32'h5, 31), 0);
    send_item(make_item(MODE_INSERT, 32'h5, 5), 0);
    send_item(make_item(MODE_APPEND, 32'hFFFF_FFFF, 0), 0);
    send_item(make_item(MODE_SEARCH, 32'hFFFF_FFFF, 0), 3);
    send_item(make_item(MODE_DELETE, 32'hFFFF_FFFF, 0), 0);
    send_item(make_item(MODE_SEARCH, 32'hFFFF_FFFF, 0), 0);
    send_item(make_item(MODE_SEARCH, 32'd12345, 0), 0);
    send_item(make_item(MODE_DELETE, 32'd12345, 0), 5);
    send_item(make_item(MODE_DELETE, 32'h8000_0000, 0), 0);
    send_item(make_item(MODE_DELETE, 32'hFFFF_FFFF, 0), 0);
    for (int m = FIRST_UNUSED_MODE; m <= LAST_UNUSED_MODE; m++) begin
      send_item(make_item(3'(m), 32'h0, 0), 0);
    end
    send_item(make_item(MODE_CLEAR, 32'h0, 0), 0);
    send_item(make_item(MODE_SEARCH, 32'h7FFF_FFFF, 0), 0);

    // fill to capacity, then hit the full cases
    for (int n = 0; n < CAPACITY; n++) begin
      send_item(make_item(MODE_APPEND, pick_key(), 0), $urandom_range(0, 1));
    end
    send_item(make_item(MODE_APPEND, 32'h1, 0), 0);
    send_item(make_item(MODE_INSERT, 32'h1, 20), 0);
    send_item(make_item(MODE_INSERT, 32'h1, 0), 0);
    send_item(make_item(MODE_SEARCH, key_pool[1], 0), 0);
    send_item(make_item(MODE_CLEAR, 32'h0, 0), 0);
    wait_drained();

    while (random_sent < RANDOM_ITEMS) begin
      phase_kind = $urandom_range(0, 2);
      phase_len  = $urandom_range(20, 60);
      no_gaps    = ($urandom_range(0, 3) == 0);
      case (phase_kind)
        0: begin
          ins_cut = 40; app_cut = 75; del_cut = 87; srch_cut = 97; clr_cut = 98;
        end
        1: begin
          ins_cut = 10; app_cut = 20; del_cut = 75; srch_cut = 95; clr_cut = 98;
        end
        default: begin
          ins_cut = 20; app_cut = 40; del_cut = 70; srch_cut = 95; clr_cut = 98;
        end
      endcase
      for (int n = 0; n < phase_len; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_cut) mode = MODE_INSERT;
        else if (roll < app_cut) mode = MODE_APPEND;
        else if (roll < del_cut) mode = MODE_DELETE;
        else if (roll < srch_cut) mode = MODE_SEARCH;
        else if (roll < clr_cut) mode = MODE_CLEAR;
        else mode = 3'($urandom_range(FIRST_UNUSED_MODE, LAST_UNUSED_MODE));
        roll = $urandom_range(0, 99);
        if (roll < 50) pos = $urandom_range(0, 4);
        else if (roll < 85) pos = $urandom_range(0, CAPACITY);
        else pos = $urandom_range(0, 31);
        send_item(make_item(mode, pick_key(), pos), no_gaps ? 0 : $urandom_range(0, 5));
        if (mode <= MODE_CLEAR) random_sent++;
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(negedge clk_i);

    $display("Sent %0d insert, %0d append, %0d delete, %0d search, %0d clear items",
             mode_sent[MODE_INSERT], mode_sent[MODE_APPEND], mode_sent[MODE_DELETE],
             mode_sent[MODE_SEARCH], mode_sent[MODE_CLEAR]);
    $display("plus %0d on unused modes; %0d results compared, %0d mismatching fields",
             mode_sent[5] + mode_sent[6] + mode_sent[7], checked_count, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/skl_pkg.sv
rtl/skl_cell.sv
rtl/sequential_keyed_list.sv
tb/skl_checker.sv
tb/sequential_keyed_list_tb.sv
